### rtl/fdsu_pkg.sv
// Shared types, opcodes and operand-routing tables for the Forth data stack unit.
`default_nettype none
package fdsu_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);

  // Opcodes
  localparam logic [4:0] OP_PUSH   = 5'd0;
  localparam logic [4:0] OP_ADD    = 5'd1;
  localparam logic [4:0] OP_SUB    = 5'd2;
  localparam logic [4:0] OP_MUL    = 5'd3;
  localparam logic [4:0] OP_DIV    = 5'd4;
  localparam logic [4:0] OP_MOD    = 5'd5;
  localparam logic [4:0] OP_DIVMOD = 5'd6;
  localparam logic [4:0] OP_GT     = 5'd7;
  localparam logic [4:0] OP_LT     = 5'd8;
  localparam logic [4:0] OP_EQ     = 5'd9;
  localparam logic [4:0] OP_SWAP   = 5'd10;
  localparam logic [4:0] OP_SWAP2  = 5'd11;
  localparam logic [4:0] OP_DUP    = 5'd12;
  localparam logic [4:0] OP_DUP2   = 5'd13;
  localparam logic [4:0] OP_OVER   = 5'd14;
  localparam logic [4:0] OP_OVER2  = 5'd15;
  localparam logic [4:0] OP_DROP   = 5'd16;
  localparam logic [4:0] OP_ROT    = 5'd17;
  localparam logic [4:0] OP_PRINT  = 5'd18;
  localparam logic [4:0] OP_EMIT   = 5'd19;

  // Print kinds
  localparam logic [1:0] PK_NONE = 2'd0;
  localparam logic [1:0] PK_NUM  = 2'd1;
  localparam logic [1:0] PK_CHAR = 2'd2;

  localparam logic [31:0] TRUE_WORD = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [4:0]         kind;
    logic signed [31:0] literal;
  } fdsu_in_t;

  typedef struct packed {
    logic [1:0]         print_kind;
    logic signed [31:0] print_value;
    logic               underflow;
    logic               overflow;
    logic               div_by_zero;
    logic [8:0]         depth_after;
  } fdsu_out_t;

  // Source of a pushed word; Pn is the n-th value popped (P0 = old top)
  typedef enum logic [2:0] {
    SRC_LIT, SRC_ALU, SRC_Q, SRC_R, SRC_P0, SRC_P1, SRC_P2, SRC_P3
  } src_t;

  // Controller commands to the datapath
  typedef struct packed {
    logic       load;
    logic       pop_rd;
    logic       pop_cap;
    logic [1:0] pop_idx;
    logic       exec;
    logic       div_start;
    logic       push;
    logic [2:0] push_idx;
    logic       finish;
  } fdsu_cmd_t;

  // Datapath status to the controller
  typedef struct packed {
    logic [4:0] kind;
    logic       empty;
    logic       div_done;
  } fdsu_sts_t;

  function automatic logic [2:0] pop_count(input logic [4:0] kind);
    logic [2:0] n;
    unique case (kind)
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_DIVMOD,
      OP_GT, OP_LT, OP_EQ, OP_SWAP, OP_DUP2, OP_OVER:   n = 3'd2;
      OP_SWAP2, OP_OVER2:                               n = 3'd4;
      OP_DUP, OP_DROP, OP_PRINT, OP_EMIT:               n = 3'd1;
      OP_ROT:                                           n = 3'd3;
      default:                                          n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [2:0] push_count(input logic [4:0] kind);
    logic [2:0] n;
    unique case (kind)
      OP_PUSH, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
      OP_GT, OP_LT, OP_EQ:                 n = 3'd1;
      OP_DIVMOD, OP_SWAP, OP_DUP:          n = 3'd2;
      OP_SWAP2, OP_DUP2:                   n = 3'd4;
      OP_OVER, OP_ROT:                     n = 3'd3;
      OP_OVER2:                            n = 3'd6;
      default:                             n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic src_t push_src(input logic [4:0] kind, input logic [2:0] idx);
    src_t s;
    s = SRC_ALU;
    unique case (kind)
      OP_PUSH:         s = SRC_LIT;
      OP_DIV:          s = SRC_Q;
      OP_MOD:          s = SRC_R;
      OP_DIVMOD:       s = (idx == 3'd0) ? SRC_R : SRC_Q;
      OP_SWAP:         s = (idx == 3'd0) ? SRC_P0 : SRC_P1;
      OP_DUP:          s = SRC_P0;
      OP_SWAP2: begin
        case (idx)
          3'd0:    s = SRC_P1;
          3'd1:    s = SRC_P0;
          3'd2:    s = SRC_P3;
          default: s = SRC_P2;
        endcase
      end
      OP_DUP2, OP_OVER: s = idx[0] ? SRC_P0 : SRC_P1;
      OP_OVER2: begin
        case (idx)
          3'd0, 3'd4: s = SRC_P3;
          3'd1, 3'd5: s = SRC_P2;
          3'd2:       s = SRC_P1;
          default:    s = SRC_P0;
        endcase
      end
      OP_ROT: begin
        case (idx)
          3'd0:    s = SRC_P1;
          3'd1:    s = SRC_P0;
          default: s = SRC_P2;
        endcase
      end
      default: s = SRC_ALU;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

### rtl/forth_data_stack_unit_core.sv
// Top level of the Forth data stack unit.
// One command is taken when start is high and busy is low; the unit then
// pops its operands one at a time from the stack RAM (a read state and a
// capture state per pop, only the read state for an empty-stack pop),
// executes, and pushes results one per cycle. Div, mod and /mod then wait
// on the one-bit-per-cycle divider, which skips its shift steps when the
// divisor is zero. The result appears for exactly one cycle with out_valid,
// in the first cycle that busy is low again; the receiver cannot stall it.
// The stack needs no clearing after reset: only entries below the depth are
// ever read.
`default_nettype none
module forth_data_stack_unit_core import fdsu_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire fdsu_in_t in_data,
  output logic          out_valid,
  output fdsu_out_t     out_data
);

  fdsu_cmd_t cmd;
  fdsu_sts_t sts;

  fdsu_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  fdsu_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

### rtl/fdsu_div.sv
// Iterative restoring signed divider, one quotient bit per cycle.
`default_nettype none
module fdsu_div import fdsu_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      quot,
  output logic [31:0]      rem
);

  logic        run_r, run_nxt;
  logic        fin_r, fin_nxt;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [31:0] quo_r, dvs_r, rem_r;
  logic        neg_q_r, neg_r_r;
  logic [31:0] q_out_r, r_out_r;
  logic [32:0] rem_sh, diff;

  assign rem_sh = {rem_r, quo_r[31]};
  assign diff   = rem_sh - {1'b0, dvs_r};

  assign run_nxt = start ? (divisor != 32'd0) : (run_r && (cnt_r != 5'd31));
  assign fin_nxt = start ? (divisor == 32'd0) : (run_r && (cnt_r == 5'd31));

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      fin_r  <= fin_nxt;
      done_r <= fin_r;
      cnt_r  <= start ? 5'd0 : (run_r ? cnt_r + 5'd1 : cnt_r);
    end
  end

  // Load magnitudes, shift-subtract, then apply signs; a zero divisor loads zeros
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r   <= (divisor == 32'd0) ? 32'd0 :
                 (dividend[31] ? (32'd0 - dividend) : dividend);
      dvs_r   <= divisor[31] ? (32'd0 - divisor) : divisor;
      rem_r   <= '0;
      neg_q_r <= dividend[31] ^ divisor[31];
      neg_r_r <= dividend[31];
    end else if (run_r) begin
      if (!diff[32]) begin
        rem_r <= diff[31:0];
        quo_r <= {quo_r[30:0], 1'b1};
      end else begin
        rem_r <= rem_sh[31:0];
        quo_r <= {quo_r[30:0], 1'b0};
      end
    end
    if (fin_r) begin
      q_out_r <= neg_q_r ? (32'd0 - quo_r) : quo_r;
      r_out_r <= neg_r_r ? (32'd0 - rem_r) : rem_r;
    end
  end

  assign done = done_r;
  assign quot = q_out_r;
  assign rem  = r_out_r;

endmodule
`default_nettype wire

### rtl/fdsu_dpath.sv
// Datapath: stack memory, depth, popped operands, ALU, divider and result register.
`default_nettype none
module fdsu_dpath import fdsu_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire fdsu_in_t  in_data,
  input  wire fdsu_cmd_t cmd,
  output fdsu_sts_t      sts,
  output logic           out_valid,
  output fdsu_out_t      out_data
);

  logic [31:0]        mem [STACK_DEPTH];
  logic [31:0]        rd_r;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [4:0]         kind_r;
  logic [31:0]        lit_r;
  logic [31:0]        pop_r [4];
  logic [31:0]        alu_r;
  logic               uf_r, of_r, dz_r;
  logic               out_valid_r;
  fdsu_out_t          out_r;
  logic               empty, full;
  logic [31:0]        opa, opb, push_val;
  logic [ADDR_W-1:0]  rd_addr, wr_addr;
  logic               div_done;
  logic [31:0]        div_q, div_r;

  assign empty   = (depth_r == '0);
  assign full    = (depth_r == DEPTH_W'(STACK_DEPTH));
  assign rd_addr = ADDR_W'(depth_r - DEPTH_W'(1));
  assign wr_addr = depth_r[ADDR_W-1:0];
  assign opb     = pop_r[0];
  assign opa     = pop_r[1];

  fdsu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (opa),
    .divisor  (opb),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_r)
  );

  // Select the word to push
  always_comb begin
    case (push_src(kind_r, cmd.push_idx))
      SRC_LIT: push_val = lit_r;
      SRC_ALU: push_val = alu_r;
      SRC_Q:   push_val = div_q;
      SRC_R:   push_val = div_r;
      SRC_P0:  push_val = pop_r[0];
      SRC_P1:  push_val = pop_r[1];
      SRC_P2:  push_val = pop_r[2];
      default: push_val = pop_r[3];
    endcase
  end

  // Update depth on pops and pushes
  always_comb begin
    depth_nxt = depth_r;
    if (cmd.pop_rd && !empty) depth_nxt = depth_r - DEPTH_W'(1);
    else if (cmd.push && !full) depth_nxt = depth_r + DEPTH_W'(1);
  end

  // Stack memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.push && !full) mem[wr_addr] <= push_val;
    rd_r <= mem[rd_addr];
  end

  // Control state: depth, flags, result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r     <= '0;
      out_valid_r <= 1'b0;
      uf_r        <= 1'b0;
      of_r        <= 1'b0;
      dz_r        <= 1'b0;
    end else begin
      depth_r     <= depth_nxt;
      out_valid_r <= cmd.finish;
      if (cmd.load) begin
        uf_r <= 1'b0;
        of_r <= 1'b0;
        dz_r <= 1'b0;
      end else begin
        if (cmd.pop_rd && empty) uf_r <= 1'b1;
        if (cmd.push && full) of_r <= 1'b1;
        if (cmd.div_start && (opb == 32'd0)) dz_r <= 1'b1;
      end
    end
  end

  // Payload: item, operands, ALU result, output fields
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_data.kind;
      lit_r  <= in_data.literal;
    end
    if (cmd.pop_rd && empty) pop_r[cmd.pop_idx] <= '0;
    if (cmd.pop_cap) pop_r[cmd.pop_idx] <= rd_r;
    if (cmd.exec) begin
      case (kind_r)
        OP_ADD:  alu_r <= opa + opb;
        OP_SUB:  alu_r <= opa - opb;
        OP_MUL:  alu_r <= opa * opb;
        OP_GT:   alu_r <= ($signed(opa) > $signed(opb)) ? TRUE_WORD : 32'd0;
        OP_LT:   alu_r <= ($signed(opa) < $signed(opb)) ? TRUE_WORD : 32'd0;
        OP_EQ:   alu_r <= (opa == opb) ? TRUE_WORD : 32'd0;
        default: alu_r <= 32'd0;
      endcase
    end
    if (cmd.finish) begin
      out_r.underflow   <= uf_r;
      out_r.overflow    <= of_r;
      out_r.div_by_zero <= dz_r;
      out_r.depth_after <= 9'(depth_r);
      case (kind_r)
        OP_PRINT: begin
          out_r.print_kind  <= PK_NUM;
          out_r.print_value <= pop_r[0];
        end
        OP_EMIT: begin
          out_r.print_kind  <= PK_CHAR;
          out_r.print_value <= {24'd0, pop_r[0][7:0]};
        end
        default: begin
          out_r.print_kind  <= PK_NONE;
          out_r.print_value <= 32'd0;
        end
      endcase
    end
  end

  assign sts.kind     = kind_r;
  assign sts.empty    = empty;
  assign sts.div_done = div_done;
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;

endmodule
`default_nettype wire

### rtl/fdsu_ctrl.sv
// Controller: sequences pops, execute, divide wait and pushes for one item.
`default_nettype none
module fdsu_ctrl import fdsu_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire fdsu_sts_t sts,
  output logic           busy,
  output fdsu_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_POP_RD, S_POP_CAP, S_EXEC, S_DIV_WAIT, S_PUSH, S_DONE
  } state_t;

  state_t     state_r;
  logic [1:0] pop_idx_r;
  logic [2:0] push_idx_r;
  logic [2:0] npop, npush;
  logic       last_pop, last_push, is_div;

  assign npop      = pop_count(sts.kind);
  assign npush     = push_count(sts.kind);
  assign last_pop  = ({1'b0, pop_idx_r} == (npop - 3'd1));
  assign last_push = (push_idx_r == (npush - 3'd1));
  assign is_div    = (sts.kind == OP_DIV) || (sts.kind == OP_MOD) ||
                     (sts.kind == OP_DIVMOD);

  // Hold state and step counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      pop_idx_r  <= '0;
      push_idx_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          pop_idx_r  <= '0;
          push_idx_r <= '0;
          if (start) state_r <= S_POP_RD;
        end
        S_POP_RD: begin
          if (npop == 3'd0) begin
            state_r <= S_EXEC;
          end else if (!sts.empty) begin
            state_r <= S_POP_CAP;
          end else if (last_pop) begin
            state_r <= S_EXEC;
          end else begin
            pop_idx_r <= pop_idx_r + 2'd1;
          end
        end
        S_POP_CAP: begin
          if (last_pop) begin
            state_r <= S_EXEC;
          end else begin
            pop_idx_r <= pop_idx_r + 2'd1;
            state_r   <= S_POP_RD;
          end
        end
        S_EXEC: begin
          if (is_div) state_r <= S_DIV_WAIT;
          else if (npush != 3'd0) state_r <= S_PUSH;
          else state_r <= S_DONE;
        end
        S_DIV_WAIT: begin
          if (sts.div_done) state_r <= S_PUSH;
        end
        S_PUSH: begin
          if (last_push) state_r <= S_DONE;
          else push_idx_r <= push_idx_r + 3'd1;
        end
        S_DONE: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Decode commands from state
  always_comb begin
    cmd           = '0;
    cmd.pop_idx   = pop_idx_r;
    cmd.push_idx  = push_idx_r;
    cmd.load      = (state_r == S_IDLE) && start;
    cmd.pop_rd    = (state_r == S_POP_RD) && (npop != 3'd0);
    cmd.pop_cap   = (state_r == S_POP_CAP);
    cmd.exec      = (state_r == S_EXEC);
    cmd.div_start = (state_r == S_EXEC) && is_div;
    cmd.push      = (state_r == S_PUSH);
    cmd.finish    = (state_r == S_DONE);
  end

  assign busy = (state_r != S_IDLE);

endmodule
`default_nettype wire

### rtl/fdsu_checker.sv
// Port-level checks for the Forth data stack unit, bound to the top level.
`default_nettype none
module fdsu_checker import fdsu_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input wire logic      out_valid,
  input wire fdsu_out_t out_data
);

  // An accepted command makes the unit busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accept did not raise busy");

  // A result transfer is a single-cycle strobe
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("out_valid held over two cycles");

  // A result only appears once the unit is idle again
  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result shown while busy");

  // Nothing printed means a zero value
  a_print_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.print_kind == PK_NONE)) |-> (out_data.print_value == 32'd0))
    else $error("print_value nonzero without print");

  // Depth never exceeds the stack size
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.depth_after <= 9'(STACK_DEPTH)))
    else $error("depth_after beyond stack size");

endmodule

bind forth_data_stack_unit_core fdsu_checker u_fdsu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
`default_nettype wire

### bench/forth_data_stack_unit_checker.sv
// Stack predictor and result scoreboard for the Forth data stack unit bench.
`timescale 1ns / 1ps
module forth_data_stack_unit_checker import fdsu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  fdsu_in_t  in_data,
  input  logic      out_valid,
  input  fdsu_out_t out_data,
  output int        mismatches,
  output int        pending
);

  logic [31:0] stack_words [STACK_DEPTH];
  int unsigned stack_level;
  bit          pop_empty;
  bit          push_full;
  fdsu_out_t   expected_results [$];

  initial mismatches = 0;
  assign pending = expected_results.size();

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic logic [31:0] pop_word();
    if (stack_level == 0) begin
      pop_empty = 1'b1;
      return 32'd0;
    end
    stack_level--;
    return stack_words[stack_level];
  endfunction

  function automatic void push_word(input logic [31:0] v);
    if (stack_level >= STACK_DEPTH) begin
      push_full = 1'b1;
      return;
    end
    stack_words[stack_level] = v;
    stack_level++;
  endfunction

  // Truncating division on magnitudes; divisor is nonzero
  function automatic void split_divide(input logic [31:0] a, input logic [31:0] b,
                                       output logic [31:0] q, output logic [31:0] r);
    logic [31:0] ma, mb, mq, mr;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    mq = ma / mb;
    mr = ma % mb;
    q = (a[31] != b[31]) ? -mq : mq;
    r = a[31] ? -mr : mr;
  endfunction

  function automatic fdsu_out_t run_primitive(input fdsu_in_t cmd);
    fdsu_out_t   res;
    logic [31:0] a, b, c, d, q, r;
    res = '0;
    pop_empty = 1'b0;
    push_full = 1'b0;
    case (cmd.kind)
      OP_PUSH: push_word(cmd.literal);
      OP_ADD, OP_SUB, OP_MUL, OP_GT, OP_LT, OP_EQ: begin
        b = pop_word();
        a = pop_word();
        case (cmd.kind)
          OP_ADD:  push_word(a + b);
          OP_SUB:  push_word(a - b);
          OP_MUL:  push_word(a * b);
          OP_GT:   push_word(($signed(a) > $signed(b)) ? TRUE_WORD : 32'd0);
          OP_LT:   push_word(($signed(a) < $signed(b)) ? TRUE_WORD : 32'd0);
          default: push_word((a == b) ? TRUE_WORD : 32'd0);
        endcase
      end
      OP_DIV, OP_MOD, OP_DIVMOD: begin
        b = pop_word();
        a = pop_word();
        if (b == 0) begin
          res.div_by_zero = 1'b1;
          q = '0;
          r = '0;
        end else begin
          split_divide(a, b, q, r);
        end
        if (cmd.kind == OP_DIV) push_word(q);
        else if (cmd.kind == OP_MOD) push_word(r);
        else begin
          push_word(r);
          push_word(q);
        end
      end
      OP_SWAP: begin
        b = pop_word(); a = pop_word();
        push_word(b); push_word(a);
      end
      OP_SWAP2: begin
        d = pop_word(); c = pop_word(); b = pop_word(); a = pop_word();
        push_word(c); push_word(d); push_word(a); push_word(b);
      end
      OP_DUP: begin
        a = pop_word();
        push_word(a); push_word(a);
      end
      OP_DUP2: begin
        b = pop_word(); a = pop_word();
        push_word(a); push_word(b); push_word(a); push_word(b);
      end
      OP_OVER: begin
        b = pop_word(); a = pop_word();
        push_word(a); push_word(b); push_word(a);
      end
      OP_OVER2: begin
        d = pop_word(); c = pop_word(); b = pop_word(); a = pop_word();
        push_word(a); push_word(b); push_word(c); push_word(d);
        push_word(a); push_word(b);
      end
      OP_DROP: a = pop_word();
      OP_ROT: begin
        c = pop_word(); b = pop_word(); a = pop_word();
        push_word(b); push_word(c); push_word(a);
      end
      OP_PRINT: begin
        res.print_kind  = PK_NUM;
        res.print_value = pop_word();
      end
      OP_EMIT: begin
        res.print_kind  = PK_CHAR;
        res.print_value = pop_word() & 32'hFF;
      end
      default: ;
    endcase
    res.underflow   = pop_empty;
    res.overflow    = push_full;
    res.depth_after = stack_level[8:0];
    return res;
  endfunction

  // Predict on each input transfer, compare on each result transfer
  always @(posedge clk) begin
    fdsu_out_t want;
    if (!rst_n) begin
      stack_level = 0;
      expected_results.delete();
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          report("unexpected result", out_data.print_value, '0);
        end else begin
          want = expected_results.pop_front();
          if (out_data.print_kind != want.print_kind)
            report("print_kind", 32'(out_data.print_kind), 32'(want.print_kind));
          if (out_data.print_value != want.print_value)
            report("print_value", out_data.print_value, want.print_value);
          if (out_data.underflow != want.underflow)
            report("underflow", 32'(out_data.underflow), 32'(want.underflow));
          if (out_data.overflow != want.overflow)
            report("overflow", 32'(out_data.overflow), 32'(want.overflow));
          if (out_data.div_by_zero != want.div_by_zero)
            report("div_by_zero", 32'(out_data.div_by_zero), 32'(want.div_by_zero));
          if (out_data.depth_after != want.depth_after)
            report("depth_after", 32'(out_data.depth_after), 32'(want.depth_after));
        end
      end
      if (start && !busy) expected_results.push_back(run_primitive(in_data));
    end
  end

endmodule

### bench/forth_data_stack_unit_core_test.sv
// Top of the Forth data stack unit bench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module forth_data_stack_unit_core_test;
  import fdsu_pkg::*;

  localparam logic [4:0] OP_SPARE_LO = 5'd20;
  localparam logic [4:0] OP_SPARE_HI = 5'd31;
  localparam int RANDOM_ITEMS = 1200;
  localparam int QUIET_LIMIT  = 2000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  fdsu_in_t  in_data = '0;
  logic      out_valid;
  fdsu_out_t out_data;
  int        mismatches;
  int        pending;
  int        idle_pct = 0;
  int        quiet_cycles = 0;

  always #2 clk = ~clk;

  forth_data_stack_unit_core DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  forth_data_stack_unit_checker checker_inst (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .mismatches(mismatches),
    .pending(pending)
  );

  // Stop when nothing transfers for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Maybe idle first, then present one command and hold it until the transfer
  task automatic send_command(input logic [4:0] kind, input logic [31:0] lit);
    bit taken;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= '{kind: kind, literal: lit};
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
  endtask

  function automatic logic [31:0] pick_literal();
    case ($urandom_range(3))
      0: case ($urandom_range(4))
           0: return 32'h8000_0000;
           1: return 32'h7FFF_FFFF;
           2: return 32'hFFFF_FFFF;
           3: return 32'd1;
           default: return 32'd0;
         endcase
      1: return $urandom_range(20) - 10;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [4:0] pick_kind();
    int roll;
    roll = $urandom_range(99);
    if (roll < 40) return OP_PUSH;
    if (roll < 95) return 5'($urandom_range(OP_EMIT, OP_ADD));
    return 5'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
  endfunction

  initial begin
    int wait_cycles;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-stack pops, zero divisor, quotient wrap, every primitive
    send_command(OP_PRINT, 32'd0);
    send_command(OP_ADD, 32'd0);
    send_command(OP_PUSH, 32'd7);
    send_command(OP_PUSH, 32'd0);
    send_command(OP_DIVMOD, 32'd0);
    send_command(OP_PUSH, 32'h8000_0000);
    send_command(OP_PUSH, 32'hFFFF_FFFF);
    send_command(OP_DIV, 32'd0);
    send_command(OP_PUSH, 32'h7FFF_FFFF);
    send_command(OP_PUSH, -32'sd7);
    send_command(OP_MOD, 32'd0);
    send_command(OP_DUP2, 32'd0);
    send_command(OP_GT, 32'd0);
    send_command(OP_OVER2, 32'd0);
    send_command(OP_LT, 32'd0);
    send_command(OP_EQ, 32'd0);
    send_command(OP_SUB, 32'd0);
    send_command(OP_MUL, 32'd0);
    send_command(OP_OVER, 32'd0);
    send_command(OP_SWAP, 32'd0);
    send_command(OP_SWAP2, 32'd0);
    send_command(OP_ROT, 32'd0);
    send_command(OP_DUP, 32'd0);
    send_command(OP_EMIT, 32'd0);
    send_command(OP_DROP, 32'd0);
    send_command(OP_SPARE_HI, 32'hFFFF_FFFF);

    // Random: mixed traffic, with a fill past full and a drain past empty
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idle_pct = (i < 400) ? 6 : (i < 800) ? 54 : 0;
      if (i >= 500 && i < 762) send_command(OP_PUSH, pick_literal());
      else if (i >= 772 && i < 1040) send_command(OP_DROP, $urandom);
      else send_command(pick_kind(), pick_literal());
    end
    start <= 1'b0;

    // Drain outstanding results, then let the block settle
    while (pending != 0) @(posedge clk);
    wait_cycles = 60;
    repeat (wait_cycles) @(posedge clk);
    if (mismatches == 0 && pending == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### files.f
rtl/fdsu_pkg.sv
rtl/fdsu_div.sv
rtl/fdsu_dpath.sv
rtl/fdsu_ctrl.sv
rtl/forth_data_stack_unit_core.sv
rtl/fdsu_checker.sv
bench/forth_data_stack_unit_checker.sv
bench/forth_data_stack_unit_core_test.sv
